/* hdl/ermgr_pkg.sv */
// Shared types and constants for the epoch reclamation manager.
// No dependencies; imported by every module of the block.
`default_nettype none
package ermgr_pkg;

  localparam int THREADS_DEF = 16;
  localparam int EPOCHS_DEF  = 3;

  localparam int EPOCH_W    = 2;
  localparam int CNT_W      = 8;
  localparam int LIMBO_W    = 16;
  localparam int PEND_W     = 18;
  localparam int CMD_W      = 2;
  localparam int TID_W      = 4;
  localparam int THR_W      = 8;
  localparam int ACT_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [LIMBO_W-1:0] LIMBO_MAX     = '1;
  localparam logic [THR_W-1:0]   THRESHOLD_RST = 8'd100;
  localparam logic [ACT_W-1:0]   ACTIVE_RST    = 5'd16;
  localparam logic [EPOCH_W-1:0] EPOCH_RST     = 2'd1;

  localparam logic [CMD_W-1:0] CMD_ENTER  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXIT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RETIRE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_THREADS   = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [TID_W-1:0] thread_id;
  } in_word_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] current_epoch;
    logic [LIMBO_W-1:0] reclaimed_count;
    logic [PEND_W-1:0]  pending_count;
    logic               epoch_advanced;
  } out_word_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic               crit;
    logic [CNT_W-1:0]   cnt;
    logic [PEND_W-1:0]  pend;
  } thr_rec_t;

  localparam int THR_REC_W = $bits(thr_rec_t);

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRD,
    ST_SCAN,
    ST_LMB,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

/* hdl/ermgr_store.sv */
// Single-port-read, single-port-write store with per-entry valid bits.
// Unwritten entries read as zero. Depends on ermgr_pkg.
`default_nettype none
module ermgr_store
  import ermgr_pkg::*;
#(
  parameter int DEPTH = THREADS_DEF,
  parameter int WIDTH = THR_REC_W,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mem_ctl_t         ctl,
  input  wire logic [AW-1:0]    rd_addr,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_valid_r;
  logic [DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.wr) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule
`default_nettype wire

/* hdl/ermgr_ctrl.sv */
// Sequencer of the reclamation manager: command decode, thread scan,
// limbo update and result register. Depends on ermgr_pkg.
`default_nettype none
module ermgr_ctrl
  import ermgr_pkg::*;
#(
  parameter int THREADS = THREADS_DEF,
  parameter int EPOCHS  = EPOCHS_DEF,
  localparam int TIW = (THREADS > 1) ? $clog2(THREADS) : 1,
  localparam int LIW = $clog2(THREADS * EPOCHS)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_word_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_word_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output mem_ctl_t                   thr_ctl,
  output logic [TIW-1:0]             thr_rd_addr,
  output logic [TIW-1:0]             thr_wr_addr,
  output logic [THR_REC_W-1:0]       thr_wdata,
  input  wire logic [THR_REC_W-1:0]  thr_rdata,
  output mem_ctl_t                   lmb_ctl,
  output logic [LIW-1:0]             lmb_rd_addr,
  output logic [LIW-1:0]             lmb_wr_addr,
  output logic [LIMBO_W-1:0]         lmb_wdata,
  input  wire logic [LIMBO_W-1:0]    lmb_rdata
);

  localparam int XW   = (TIW > TID_W) ? TIW : TID_W;
  localparam int SW   = $clog2(THREADS + 1);
  localparam int CMPW = ((SW > ACT_W) ? SW : ACT_W) + 1;

  function automatic logic [LIW-1:0] slot_of(input logic [TIW-1:0] t,
                                             input logic [EPOCH_W-1:0] e);
    return LIW'(LIW'(t) * LIW'(EPOCHS) + LIW'(e));
  endfunction

  state_t              state_r, state_nxt;
  logic [EPOCH_W-1:0]  ge_r, ge_nxt;
  logic [THR_W-1:0]    thr_r, thr_nxt;
  logic [ACT_W-1:0]    act_r, act_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                chk_r, chk_nxt;
  logic [SW-1:0]       scan_idx_r, scan_idx_nxt;

  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [TIW-1:0]      tid_r, tid_nxt;
  logic                rng_r, rng_nxt;
  logic                adv_r, adv_nxt;
  logic                recl_r, recl_nxt;
  logic [LIW-1:0]      slot_r, slot_nxt;
  thr_rec_t            rec_r, rec_nxt;
  out_word_t           res_r, res_nxt;
  out_word_t           out_r, out_nxt;

  logic [XW-1:0]       in_tid_x;
  logic [TIW-1:0]      in_tid;
  logic                in_rng;
  thr_rec_t            rec_in;
  thr_rec_t            rec_w;
  logic [EPOCH_W-1:0]  ge_inc;
  logic                blk;
  logic                scan_done;
  logic                load_out;
  logic [PEND_W-1:0]   pend_w;

  assign in_tid_x  = XW'(in_data.thread_id);
  assign in_tid    = in_tid_x[TIW-1:0];
  assign in_rng    = ({1'b0, in_tid_x} < (XW + 1)'(THREADS));
  assign rec_in    = thr_rec_t'(thr_rdata);
  assign ge_inc    = (ge_r == EPOCH_W'(EPOCHS - 1)) ? '0 : ge_r + EPOCH_W'(1);
  assign blk       = chk_r && rec_in.crit && (rec_in.epoch != ge_r);
  assign scan_done = (CMPW'(scan_idx_r) >= CMPW'(act_r)) ||
                     (CMPW'(scan_idx_r) >= CMPW'(THREADS));
  assign load_out  = !out_valid_r || out_ready;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_TRD;
        end
      end
      ST_TRD: begin
        if (!rng_r) begin
          state_nxt = ST_OUT;
        end else begin
          case (cmd_r)
            CMD_ENTER: begin
              if (rec_in.epoch != ge_r) begin
                state_nxt = ST_LMB;
              end else if (rec_in.cnt == thr_r) begin
                state_nxt = ST_SCAN;
              end else begin
                state_nxt = ST_OUT;
              end
            end
            CMD_RETIRE: state_nxt = ST_LMB;
            default:    state_nxt = ST_OUT;
          endcase
        end
      end
      ST_SCAN: begin
        if (blk) begin
          state_nxt = ST_OUT;
        end else if (scan_done) begin
          state_nxt = ST_LMB;
        end
      end
      ST_LMB: state_nxt = ST_OUT;
      ST_OUT: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ge_nxt        = ge_r;
    thr_nxt       = thr_r;
    act_nxt       = act_r;
    chk_nxt       = chk_r;
    scan_idx_nxt  = scan_idx_r;
    cmd_nxt       = cmd_r;
    tid_nxt       = tid_r;
    rng_nxt       = rng_r;
    adv_nxt       = adv_r;
    recl_nxt      = recl_r;
    slot_nxt      = slot_r;
    rec_nxt       = rec_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rec_w         = rec_r;
    pend_w        = rec_r.pend;
    thr_ctl       = '0;
    thr_rd_addr   = in_tid;
    thr_wr_addr   = tid_r;
    lmb_ctl       = '0;
    lmb_rd_addr   = slot_r;
    lmb_wr_addr   = slot_r;
    lmb_wdata     = '0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_UPDATE_THRESHOLD: thr_nxt = cfg_data[THR_W-1:0];
        CFG_ACTIVE_THREADS:   act_nxt = cfg_data[ACT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        thr_ctl.rd = in_valid && in_rng;
        if (in_valid) begin
          cmd_nxt = in_data.command;
          tid_nxt = in_tid;
          rng_nxt = in_rng;
          adv_nxt = 1'b0;
        end
      end
      ST_TRD: begin
        rec_nxt = rec_in;
        res_nxt = '{current_epoch: ge_r, reclaimed_count: '0,
                    pending_count: rng_r ? rec_in.pend : '0, epoch_advanced: 1'b0};
        rec_w   = rec_in;
        if (rng_r) begin
          case (cmd_r)
            CMD_ENTER: begin
              if (rec_in.epoch != ge_r) begin
                recl_nxt    = 1'b1;
                slot_nxt    = slot_of(tid_r, ge_r);
                lmb_rd_addr = slot_nxt;
                lmb_ctl.rd  = 1'b1;
              end else if (rec_in.cnt == thr_r) begin
                scan_idx_nxt = '0;
                chk_nxt      = 1'b0;
              end else begin
                rec_w.crit = 1'b1;
                rec_w.cnt  = rec_in.cnt + CNT_W'(1);
                thr_ctl.wr = 1'b1;
              end
            end
            CMD_EXIT: begin
              rec_w.crit = 1'b0;
              thr_ctl.wr = 1'b1;
            end
            CMD_RETIRE: begin
              recl_nxt    = 1'b0;
              slot_nxt    = slot_of(tid_r, rec_in.epoch);
              lmb_rd_addr = slot_nxt;
              lmb_ctl.rd  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        thr_rd_addr = scan_idx_r[TIW-1:0];
        if (blk) begin
          rec_w.crit = 1'b1;
          rec_w.cnt  = CNT_W'(1);
          thr_ctl.wr = 1'b1;
          res_nxt    = '{current_epoch: ge_r, reclaimed_count: '0,
                         pending_count: rec_r.pend, epoch_advanced: 1'b0};
        end else if (scan_done) begin
          ge_nxt      = ge_inc;
          adv_nxt     = 1'b1;
          recl_nxt    = 1'b1;
          slot_nxt    = slot_of(tid_r, ge_inc);
          lmb_rd_addr = slot_nxt;
          lmb_ctl.rd  = 1'b1;
        end else begin
          thr_ctl.rd   = 1'b1;
          scan_idx_nxt = scan_idx_r + SW'(1);
          chk_nxt      = 1'b1;
        end
      end
      ST_LMB: begin
        if (recl_r) begin
          pend_w      = rec_r.pend - PEND_W'(lmb_rdata);
          lmb_ctl.wr  = 1'b1;
          lmb_wdata   = '0;
          rec_w       = '{epoch: ge_r, crit: 1'b1, cnt: '0, pend: pend_w};
          thr_ctl.wr  = 1'b1;
          res_nxt     = '{current_epoch: ge_r, reclaimed_count: lmb_rdata,
                          pending_count: pend_w, epoch_advanced: adv_r};
        end else begin
          if (lmb_rdata != LIMBO_MAX) begin
            pend_w     = rec_r.pend + PEND_W'(1);
            lmb_ctl.wr = 1'b1;
            lmb_wdata  = lmb_rdata + LIMBO_W'(1);
            rec_w.pend = pend_w;
            thr_ctl.wr = 1'b1;
          end
          res_nxt = '{current_epoch: ge_r, reclaimed_count: '0,
                      pending_count: pend_w, epoch_advanced: 1'b0};
        end
      end
      ST_OUT: begin
        if (load_out) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
    thr_wdata = THR_REC_W'(rec_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ge_r        <= EPOCH_RST;
      thr_r       <= THRESHOLD_RST;
      act_r       <= ACTIVE_RST;
      out_valid_r <= 1'b0;
      chk_r       <= 1'b0;
      scan_idx_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      ge_r        <= ge_nxt;
      thr_r       <= thr_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
      chk_r       <= chk_nxt;
      scan_idx_r  <= scan_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    tid_r  <= tid_nxt;
    rng_r  <= rng_nxt;
    adv_r  <= adv_nxt;
    recl_r <= recl_nxt;
    slot_r <= slot_nxt;
    rec_r  <= rec_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

endmodule
`default_nettype wire

/* hdl/epoch_reclamation_manager_core.sv */
// Epoch reclamation manager top level: sequencer plus thread and limbo stores.
// Depends on ermgr_pkg, ermgr_store and ermgr_ctrl.
//
// Usage: one input word (command, thread_id) is taken on in_valid && in_ready
// and yields exactly one result word on the out_ channel. in_ready is high
// only while the sequencer is idle, so one word is worked on at a time.
// A word goes from the read state straight to the output state for exit, an
// unknown command, an out-of-range thread or a plain enter; retire and an enter
// that finds its epoch stale pass through the limbo update between them; an
// enter that reaches the threshold scans threads one per cycle on the thread
// store read port, up to min(active_threads, THREADS) of them, then does the
// limbo update unless a thread critical in another epoch ends the scan early.
// in_ready rises on the same edge as out_valid. The result sits in an output
// register; a stalled receiver holds it there while the next word is accepted
// and processed; that word waits in the final state till the register frees.
// Reset (synchronous, active low) empties both stores through their valid
// bits, sets the global epoch to 1, the threshold to 100 and the scanned
// thread count to 16. cfg_ writes are registered and apply from the next cycle.
`default_nettype none
module epoch_reclamation_manager_core
  import ermgr_pkg::*;
#(
  parameter int THREADS = THREADS_DEF,
  parameter int EPOCHS  = EPOCHS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_word_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_word_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TIW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int LIW = $clog2(THREADS * EPOCHS);

  mem_ctl_t             thr_ctl;
  logic [TIW-1:0]       thr_rd_addr;
  logic [TIW-1:0]       thr_wr_addr;
  logic [THR_REC_W-1:0] thr_wdata;
  logic [THR_REC_W-1:0] thr_rdata;
  mem_ctl_t             lmb_ctl;
  logic [LIW-1:0]       lmb_rd_addr;
  logic [LIW-1:0]       lmb_wr_addr;
  logic [LIMBO_W-1:0]   lmb_wdata;
  logic [LIMBO_W-1:0]   lmb_rdata;

  ermgr_ctrl #(
    .THREADS (THREADS),
    .EPOCHS  (EPOCHS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .thr_ctl     (thr_ctl),
    .thr_rd_addr (thr_rd_addr),
    .thr_wr_addr (thr_wr_addr),
    .thr_wdata   (thr_wdata),
    .thr_rdata   (thr_rdata),
    .lmb_ctl     (lmb_ctl),
    .lmb_rd_addr (lmb_rd_addr),
    .lmb_wr_addr (lmb_wr_addr),
    .lmb_wdata   (lmb_wdata),
    .lmb_rdata   (lmb_rdata)
  );

  ermgr_store #(
    .DEPTH (THREADS),
    .WIDTH (THR_REC_W)
  ) u_thr_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (thr_ctl),
    .rd_addr (thr_rd_addr),
    .wr_addr (thr_wr_addr),
    .wr_data (thr_wdata),
    .rd_data (thr_rdata)
  );

  ermgr_store #(
    .DEPTH (THREADS * EPOCHS),
    .WIDTH (LIMBO_W)
  ) u_lmb_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (lmb_ctl),
    .rd_addr (lmb_rd_addr),
    .wr_addr (lmb_wr_addr),
    .wr_data (lmb_wdata),
    .rd_data (lmb_rdata)
  );

endmodule
`default_nettype wire

/* hdl/ermgr_checker.sv */
// Port-level checks for the epoch reclamation manager, bound to the top level.
// Depends on ermgr_pkg and epoch_reclamation_manager_core.
`default_nettype none
module ermgr_checker
  import ermgr_pkg::*;
#(
  parameter int EPOCHS = EPOCHS_DEF
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_word_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_epoch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.current_epoch < EPOCH_W'(EPOCHS)))
    else $error("epoch out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.command == in_data.command) |=> !in_ready)
    else $error("second word taken while busy");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the channels");

endmodule

bind epoch_reclamation_manager_core ermgr_checker #(.EPOCHS(EPOCHS)) u_ermgr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
